@@ rtl/rcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rcfr_pkg: shared types and constants of the RC frame receiver
// Holds the CRC-16/CCITT byte update, the channel store geometry, the
// frame command passed from the parser to the emitter and the emitter states.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfr_pkg;

	localparam int          STORE_DEPTH = 16;
	localparam int          STORE_AW    = 4;
	localparam int          COUNT_W     = 5;   // holds 0 .. STORE_DEPTH
	localparam int          POS_W       = 10;
	localparam int          QUEUE_DEPTH = 2;
	localparam int          QUEUE_AW    = 1;
	localparam logic [7:0]  SYNC_RESET  = 8'hA8;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_TOP     = 16'h8000;

	// Finished good frame: number of kept channels and its status byte.
	typedef struct packed {
		logic [COUNT_W-1:0] num;
		logic [7:0]         status;
	} frame_cmd_t;

	// Write port into the channel store.
	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [15:0]         data;
	} store_wr_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_FETCH,
		EM_SHOW
	} emit_state_t;

	// One byte of CRC-16/CCITT, MSB first, no reflection.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/rcfr_ifs.sv @@
// ----------------------------------------------------------------------------
// rcfr_ifs: channel interfaces of the RC frame receiver
// Received byte stream, channel result stream and sync value write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfr_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic [7:0]  frame_status;
	logic        last_channel;
	modport source (output valid, output channel_index, output channel_value,
		output frame_status, output last_channel, input ready);
	modport sink   (input valid, input channel_index, input channel_value,
		input frame_status, input last_channel, output ready);
endinterface

interface rcfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] sync_value;
	modport source (output valid, output sync_value, input ready);
	modport sink   (input valid, input sync_value, output ready);
endinterface

`default_nettype wire

@@ rtl/rcfr_front.sv @@
// ----------------------------------------------------------------------------
// rcfr_front: frame parser
// Tracks the byte position, runs the CRC, writes channel words into the
// store and queues a command for every good frame with kept channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_front #(
	parameter int KEEP = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                pending,
	input  wire logic                q_full,
	output logic                     q_push,
	output rcfr_pkg::frame_cmd_t     q_cmd,
	output rcfr_pkg::store_wr_t      st_wr
);
	import rcfr_pkg::*;

	logic [7:0]       sync_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       count_q;
	logic [7:0]       status_q;
	logic [15:0]      crc_q;
	logic [7:0]       rx_hi_q;
	logic [7:0]       hold_q;

	logic [POS_W-1:0] data_end;
	logic [POS_W-1:0] d;
	logic [8:0]       k;
	logic             is_sync, is_stat, is_cnt, is_data, is_crch, is_fin;
	logic             kept, accept, crc_ok;
	logic [15:0]      crc_next;
	logic [COUNT_W-1:0] num;

	assign data_end = {1'b0, count_q, 1'b0} + POS_W'(3);
	assign d        = pos_q - POS_W'(3);
	assign k        = d[POS_W-1:1];
	assign kept     = (k < 9'(KEEP));
	assign crc_next = crc_feed(crc_q, rx_byte);

	always_comb begin
		is_sync = 1'b0;
		is_stat = 1'b0;
		is_cnt  = 1'b0;
		is_data = 1'b0;
		is_crch = 1'b0;
		is_fin  = 1'b0;
		if (pos_q == POS_W'(0)) begin
			is_sync = 1'b1;
		end else if (pos_q == POS_W'(1)) begin
			is_stat = 1'b1;
		end else if (pos_q == POS_W'(2)) begin
			is_cnt = 1'b1;
		end else if (pos_q < data_end) begin
			is_data = 1'b1;
		end else if (pos_q == data_end) begin
			is_crch = 1'b1;
		end else begin
			is_fin = 1'b1;
		end
	end

	// Hold off a store write while the emitter still owns the store, and a final CRC byte while the queue is full.
	assign rx_ready = !((is_data && d[0] && kept && pending) || (is_fin && q_full));
	assign accept   = rx_valid && rx_ready;
	assign crc_ok   = ({rx_hi_q, rx_byte} == crc_q);

	always_comb begin
		if (count_q > 8'(KEEP)) begin
			num = COUNT_W'(KEEP);
		end else begin
			num = count_q[COUNT_W-1:0];
		end
	end

	assign q_cmd.num    = num;
	assign q_cmd.status = status_q;
	assign q_push       = accept && is_fin && crc_ok && (num != '0);

	assign st_wr.en   = accept && is_data && d[0] && kept;
	assign st_wr.addr = k[STORE_AW-1:0];
	assign st_wr.data = {hold_q, rx_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= SYNC_RESET;
			pos_q    <= '0;
			count_q  <= '0;
			status_q <= '0;
			crc_q    <= '0;
			rx_hi_q  <= '0;
			hold_q   <= '0;
		end else begin
			if (cfg_valid) begin
				sync_q <= cfg_data;
			end
			if (accept) begin
				if (is_sync) begin
					if (rx_byte == sync_q) begin
						crc_q <= crc_feed(16'h0000, rx_byte);
						pos_q <= POS_W'(1);
					end
				end else if (is_stat || is_cnt) begin
					if (is_stat) begin
						status_q <= rx_byte;
					end else begin
						count_q <= rx_byte;
					end
					crc_q <= crc_next;
					pos_q <= pos_q + POS_W'(1);
				end else if (is_data) begin
					crc_q <= crc_next;
					if (!d[0]) begin
						hold_q <= rx_byte;
					end
					pos_q <= pos_q + POS_W'(1);
				end else if (is_crch) begin
					rx_hi_q <= rx_byte;
					pos_q   <= pos_q + POS_W'(1);
				end else begin
					pos_q <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/rcfr_queue.sv @@
// ----------------------------------------------------------------------------
// rcfr_queue: frame command queue
// Two-entry FIFO of good-frame commands between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  rcfr_pkg::frame_cmd_t      push_cmd,
	input  wire logic                 pop,
	output rcfr_pkg::frame_cmd_t      pop_cmd,
	output logic                      full,
	output logic                      not_empty
);
	import rcfr_pkg::*;

	frame_cmd_t          slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_push, do_pop;

	assign full      = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/rcfr_back.sv @@
// ----------------------------------------------------------------------------
// rcfr_back: channel emitter
// Owns the channel store and plays out one result per kept channel of a
// good frame, reading one store entry per result.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  rcfr_pkg::store_wr_t    st_wr,
	input  wire logic              q_not_empty,
	input  rcfr_pkg::frame_cmd_t   q_cmd,
	output logic                   q_pop,
	output logic                   busy,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic [3:0]             channel_index,
	output logic [15:0]            channel_value,
	output logic [7:0]             frame_status,
	output logic                   last_channel
);
	import rcfr_pkg::*;

	logic [15:0]         mem [STORE_DEPTH];
	logic [15:0]         rdata_q;
	emit_state_t         state_q, state_d;
	logic [STORE_AW-1:0] k_q;
	logic [COUNT_W-1:0]  num_q;
	logic [7:0]          status_q;
	logic                is_last;

	always_ff @(posedge clk) begin
		if (st_wr.en) begin
			mem[st_wr.addr] <= st_wr.data;
		end
		if (state_q == EM_FETCH) begin
			rdata_q <= mem[k_q];
		end
	end

	assign is_last = (({1'b0, k_q} + COUNT_W'(1)) == num_q);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			EM_IDLE: begin
				if (q_not_empty) begin
					q_pop   = 1'b1;
					state_d = EM_FETCH;
				end
			end
			EM_FETCH: begin
				state_d = EM_SHOW;
			end
			EM_SHOW: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = is_last ? EM_IDLE : EM_FETCH;
				end
			end
			default: begin
				state_d = EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EM_IDLE;
			k_q      <= '0;
			num_q    <= '0;
			status_q <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				k_q      <= '0;
				num_q    <= q_cmd.num;
				status_q <= q_cmd.status;
			end else if (state_q == EM_SHOW && res_ready && !is_last) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	assign busy          = (state_q != EM_IDLE);
	assign channel_index = k_q;
	assign channel_value = rdata_q;
	assign frame_status  = status_q;
	assign last_channel  = is_last;

endmodule

`default_nettype wire

@@ rtl/rc_frame_receiver_crc16_top.sv @@
// ----------------------------------------------------------------------------
// rc_frame_receiver_crc16_top: serial RC frame receiver with CRC-16/CCITT
// Decodes sync-framed channel frames and emits one result per kept channel.
// ----------------------------------------------------------------------------
// Usage:
// The rx channel takes one received byte per transfer. The parser takes a
// byte in the cycle it is offered, so the byte rate is one per cycle, except
// that a byte completing a kept channel word waits while results of the
// previous good frame are still being emitted, since both share the store.
// A frame is sync, status, count N, N big-endian channel words and a 16-bit
// CRC over everything before it. A good frame produces min(N, MAX_CHANNELS,
// 16) results on the res channel, in channel order, the last one flagged.
// The first result is valid once its command has passed the queue and the
// emitter has fetched the first store entry; each further one waits for a
// fetch after the previous transfer, limited by the store's registered read.
// A bad CRC or a frame with no kept channels gives no result.
// If the res receiver stalls, the current result holds and the parser keeps
// taking header and high bytes of the next frame; a command queue of two
// frames separates parser and emitter and holds off a final CRC byte when full.
// The cfg channel writes the sync byte at any transfer and is always ready.
// Reset sets the sync byte to 0xA8, the parser to hunt for sync and the
// emitter to idle. The store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_frame_receiver_crc16_top #(
	parameter int MAX_CHANNELS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rcfr_cfg_if.sink   cfg,
	rcfr_rx_if.sink    rx,
	rcfr_res_if.source res
);
	import rcfr_pkg::*;

	localparam int KEEP = (MAX_CHANNELS < STORE_DEPTH) ? MAX_CHANNELS : STORE_DEPTH;

	frame_cmd_t push_cmd, pop_cmd;
	store_wr_t  st_wr;
	logic       q_push, q_pop, q_full, q_not_empty, busy;
	logic       pending;
	logic       rx_ready;

	assign cfg.ready = 1'b1;
	assign rx.ready  = rx_ready;

	// The store is owned by the emitter from the moment a frame is queued
	// until its last result has been transferred.
	assign pending = busy || q_not_empty;

	rcfr_front #(
		.KEEP(KEEP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg.valid),
		.cfg_data (cfg.sync_value),
		.rx_valid (rx.valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx.rx_byte),
		.pending  (pending),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.st_wr    (st_wr)
	);

	rcfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.not_empty(q_not_empty)
	);

	rcfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.st_wr        (st_wr),
		.q_not_empty  (q_not_empty),
		.q_cmd        (pop_cmd),
		.q_pop        (q_pop),
		.busy         (busy),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.channel_index(res.channel_index),
		.channel_value(res.channel_value),
		.frame_status (res.frame_status),
		.last_channel (res.last_channel)
	);

endmodule

`default_nettype wire

@@ rtl/rcfr_checker.sv @@
// ----------------------------------------------------------------------------
// rcfr_checker: port-level checks of the RC frame receiver
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_checker #(
	parameter int MAX_CHANNELS = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [3:0]  channel_index,
	input wire logic [15:0] channel_value,
	input wire logic [7:0]  frame_status,
	input wire logic        last_channel
);

	logic res_xfer;
	assign res_xfer = res_valid && res_ready;

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(channel_index)
			&& $stable(channel_value) && $stable(frame_status) && $stable(last_channel))
		else $error("stalled result changed");

	// Within a frame the next channel follows once its store entry is fetched, with the same status.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && !last_channel |-> ##2 (res_valid
			&& channel_index == $past(channel_index, 2) + 4'd1
			&& frame_status == $past(frame_status, 2)))
		else $error("frame results not consecutive");

	// After the last result the emitter goes back to idle before anything new.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && last_channel |=> !res_valid)
		else $error("result right after last channel");

	// Only kept channels are emitted.
	a_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(channel_index) < MAX_CHANNELS))
		else $error("channel index beyond kept range");

endmodule

bind rc_frame_receiver_crc16_top rcfr_checker #(
	.MAX_CHANNELS(MAX_CHANNELS)
) u_rcfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.channel_index(res.channel_index),
	.channel_value(res.channel_value),
	.frame_status (res.frame_status),
	.last_channel (res.last_channel)
);

`default_nettype wire
